/* rtl/tpq_pkg.sv */
package tpq_pkg;

    // Fixed-point formats.
    localparam int COORD_FRAC_BITS = 16;
    localparam int NORM_BITS       = 30;
    localparam int U_FRAC          = 30;

    // Widths of the normalize, square root and divide datapaths.
    localparam int SUM_W     = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS = NORM_BITS + 1;
    localparam int QUO_BITS  = U_FRAC + 1;
    localparam int NUM_W     = NORM_BITS + U_FRAC + 1;

    // Rounding shifts for the three kinds of output entry.
    localparam int K_UU = 2 * U_FRAC - 32;
    localparam int K_UD = 2 * U_FRAC + COORD_FRAC_BITS - 32;
    localparam int K_DD = 2 * U_FRAC + 2 * COORD_FRAC_BITS - 32;

    // Places of the quadric entries in a result.
    localparam int NUM_Q = 10;
    localparam int Q_XX  = 0;
    localparam int Q_XY  = 1;
    localparam int Q_XZ  = 2;
    localparam int Q_XD  = 3;
    localparam int Q_YY  = 4;
    localparam int Q_YZ  = 5;
    localparam int Q_YD  = 6;
    localparam int Q_ZZ  = 7;
    localparam int Q_ZD  = 8;
    localparam int Q_DD  = 9;

    // What travels with an item from normalization to the back end.
    typedef struct packed {
        logic [2:0][31:0]          a;
        logic [2:0]                neg;
        logic                      degen;
        logic [2:0][NORM_BITS-1:0] m;
    } t_carry;

    // One finished result.
    typedef struct packed {
        logic                   degen;
        logic [NUM_Q-1:0][63:0] q;
    } t_result;

endpackage

/* rtl/triangle_plane_quadric.sv */
// Plane quadric of one triangle: normal, unit normal, plane offset, ten quadric entries.
// Stages: 9 front, 31 square root, 32 divide and 7 back stages, then the output queue.
// Throughput: one item per cycle; the whole pipeline advances while the two-entry
// output queue has room, so only a full queue stops it.
// Reset: synchronous, active low; clears all valid bits and empties the queue.
module triangle_plane_quadric (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic signed [31:0]  i_c_x,
    input  logic signed [31:0]  i_c_y,
    input  logic signed [31:0]  i_c_z,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [63:0]  o_q_xx,
    output logic signed [63:0]  o_q_xy,
    output logic signed [63:0]  o_q_xz,
    output logic signed [63:0]  o_q_xd,
    output logic signed [63:0]  o_q_yy,
    output logic signed [63:0]  o_q_yz,
    output logic signed [63:0]  o_q_yd,
    output logic signed [63:0]  o_q_zz,
    output logic signed [63:0]  o_q_zd,
    output logic signed [63:0]  o_q_dd,
    output logic                o_degenerate
);
    import tpq_pkg::*;

    logic                      w_en;
    logic [2:0][31:0]          w_a;
    logic [2:0][31:0]          w_b;
    logic [2:0][31:0]          w_c;
    logic                      w_f_vld;
    t_carry                    w_f_car;
    logic [SUM_W-1:0]          w_f_sum;
    logic                      w_s_vld;
    t_carry                    w_s_car;
    logic [ROOT_BITS-1:0]      w_s_root;
    logic                      w_d_vld;
    t_carry                    w_d_car;
    logic [2:0][QUO_BITS-1:0]  w_d_quo;
    logic                      w_b_vld;
    t_result                   w_b_res;
    logic                      w_push;
    logic                      w_pop;

    t_result                   r_fifo [2];
    logic                      r_wr;
    logic                      r_rd;
    logic [1:0]                r_cnt;
    t_result                   w_head;

    // The pipeline moves as one while the output queue is not full.
    assign w_en    = (r_cnt != 2'd2);
    assign o_ready = w_en;

    assign w_a = {i_a_z, i_a_y, i_a_x};
    assign w_b = {i_b_z, i_b_y, i_b_x};
    assign w_c = {i_c_z, i_c_y, i_c_x};

    tpq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_valid (w_f_vld),
        .o_carry (w_f_car),
        .o_sum   (w_f_sum)
    );

    tpq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_carry (w_f_car),
        .i_sum   (w_f_sum),
        .o_valid (w_s_vld),
        .o_carry (w_s_car),
        .o_root  (w_s_root)
    );

    tpq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_vld),
        .i_carry (w_s_car),
        .i_root  (w_s_root),
        .o_valid (w_d_vld),
        .o_carry (w_d_car),
        .o_quo   (w_d_quo)
    );

    tpq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_d_vld),
        .i_carry  (w_d_car),
        .i_quo    (w_d_quo),
        .o_valid  (w_b_vld),
        .o_result (w_b_res)
    );

    // Two-entry output queue between the pipeline and the consumer.
    assign w_push = w_b_vld && w_en;
    assign w_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr] <= w_b_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign w_head       = r_fifo[r_rd];
    assign o_valid      = (r_cnt != 2'd0);
    assign o_degenerate = w_head.degen;
    assign o_q_xx       = w_head.q[Q_XX];
    assign o_q_xy       = w_head.q[Q_XY];
    assign o_q_xz       = w_head.q[Q_XZ];
    assign o_q_xd       = w_head.q[Q_XD];
    assign o_q_yy       = w_head.q[Q_YY];
    assign o_q_yz       = w_head.q[Q_YZ];
    assign o_q_yd       = w_head.q[Q_YD];
    assign o_q_zz       = w_head.q[Q_ZZ];
    assign o_q_zd       = w_head.q[Q_ZD];
    assign o_q_dd       = w_head.q[Q_DD];

    // A full queue that is not drained stays full.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_ready) |=> (r_cnt == 2'd2))
        else $error("output queue lost an item while stalled");

    // A push without a pop grows the queue by exactly one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("output queue count out of step with pushes");

    // A degenerate triangle gives all-zero entries; q_xx, q_xd and q_dd are checked.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_q_xx == 0 && o_q_xd == 0 && o_q_dd == 0))
        else $error("degenerate triangle with nonzero entries");

    // Diagonal entries of the unit normal are never negative.
    a_diag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_q_xx[63] && !o_q_yy[63] && !o_q_zz[63]))
        else $error("negative diagonal quadric entry");

endmodule

/* rtl/tpq_front.sv */
module tpq_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0][31:0]            i_a,
    input  logic [2:0][31:0]            i_b,
    input  logic [2:0][31:0]            i_c,
    output logic                        o_valid,
    output tpq_pkg::t_carry             o_carry,
    output logic [tpq_pkg::SUM_W-1:0]   o_sum
);
    import tpq_pkg::*;

    localparam int NGRP = 6;
    localparam int GW   = 11;

    logic [8:0] r_vld;

    // Stage A: edge vectors.
    logic [2:0][31:0]   r_a_a;
    logic signed [32:0] r_a_e1 [3];
    logic signed [32:0] r_a_e2 [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_a <= i_a;
            for (int i = 0; i < 3; i++) begin
                r_a_e1[i] <= 33'(signed'(i_b[i])) - 33'(signed'(i_a[i]));
                r_a_e2[i] <= 33'(signed'(i_c[i])) - 33'(signed'(i_a[i]));
            end
        end
    end

    // Stage B: the six cross product terms.
    logic [2:0][31:0]   r_b_a;
    logic signed [65:0] r_b_p [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_a    <= r_a_a;
            r_b_p[0] <= r_a_e1[1] * r_a_e2[2];
            r_b_p[1] <= r_a_e1[2] * r_a_e2[1];
            r_b_p[2] <= r_a_e1[2] * r_a_e2[0];
            r_b_p[3] <= r_a_e1[0] * r_a_e2[2];
            r_b_p[4] <= r_a_e1[0] * r_a_e2[1];
            r_b_p[5] <= r_a_e1[1] * r_a_e2[0];
        end
    end

    // Stage C: exact normal components.
    logic [2:0][31:0]   r_c_a;
    logic signed [66:0] r_c_n [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_a <= r_b_a;
            for (int i = 0; i < 3; i++) begin
                r_c_n[i] <= 67'(r_b_p[2*i]) - 67'(r_b_p[2*i+1]);
            end
        end
    end

    // Stage D: sign and magnitude.
    logic [2:0][31:0] r_d_a;
    logic [2:0]       r_d_neg;
    logic [65:0]      r_d_mag [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_a <= r_c_a;
            for (int i = 0; i < 3; i++) begin
                r_d_neg[i] <= r_c_n[i][66];
                r_d_mag[i] <= r_c_n[i][66] ? 66'(-r_c_n[i]) : 66'(r_c_n[i]);
            end
        end
    end

    // Stage E: bit length of each group of the OR of the magnitudes.
    logic [65:0]      w_or;
    logic [NGRP-1:0]  w_nz;
    logic [3:0]       w_len [NGRP];
    logic [2:0][31:0] r_e_a;
    logic [2:0]       r_e_neg;
    logic [65:0]      r_e_mag [3];
    logic [NGRP-1:0]  r_e_nz;
    logic [3:0]       r_e_len [NGRP];

    assign w_or = r_d_mag[0] | r_d_mag[1] | r_d_mag[2];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_nz[g]  = |w_or[g*GW +: GW];
            w_len[g] = '0;
            for (int b = 0; b < GW; b++) begin
                if (w_or[g*GW + b]) begin
                    w_len[g] = 4'(b + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_a   <= r_d_a;
            r_e_neg <= r_d_neg;
            r_e_mag <= r_d_mag;
            r_e_nz  <= w_nz;
            r_e_len <= w_len;
        end
    end

    // Stage F: overall bit length from the highest nonzero group.
    logic [6:0]       w_maxb;
    logic [2:0][31:0] r_f_a;
    logic [2:0]       r_f_neg;
    logic [65:0]      r_f_mag [3];
    logic [6:0]       r_f_maxb;
    logic             r_f_degen;

    always_comb begin
        w_maxb = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_e_nz[g]) begin
                w_maxb = 7'(g * GW) + 7'(r_e_len[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_a     <= r_e_a;
            r_f_neg   <= r_e_neg;
            r_f_mag   <= r_e_mag;
            r_f_maxb  <= w_maxb;
            r_f_degen <= (w_maxb == '0);
        end
    end

    // Stage G: normalize so that the largest magnitude has NORM_BITS bits.
    logic [2:0][31:0]          r_g_a;
    logic [2:0]                r_g_neg;
    logic                      r_g_degen;
    logic [2:0][NORM_BITS-1:0] r_g_m;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_a     <= r_f_a;
            r_g_neg   <= r_f_neg;
            r_g_degen <= r_f_degen;
            for (int i = 0; i < 3; i++) begin
                if (r_f_maxb > 7'(NORM_BITS)) begin
                    r_g_m[i] <= NORM_BITS'(r_f_mag[i] >> (r_f_maxb - 7'(NORM_BITS)));
                end else begin
                    r_g_m[i] <= NORM_BITS'(r_f_mag[i] << (7'(NORM_BITS) - r_f_maxb));
                end
            end
        end
    end

    // Stage H: squares.
    t_carry                 r_h_car;
    logic [2*NORM_BITS-1:0] r_h_sq [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_car.a     <= r_g_a;
            r_h_car.neg   <= r_g_neg;
            r_h_car.degen <= r_g_degen;
            r_h_car.m     <= r_g_m;
            for (int i = 0; i < 3; i++) begin
                r_h_sq[i] <= r_g_m[i] * r_g_m[i];
            end
        end
    end

    // Stage I: sum of squares.
    t_carry           r_i_car;
    logic [SUM_W-1:0] r_i_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i_car <= r_h_car;
            r_i_sum <= SUM_W'(r_h_sq[0]) + SUM_W'(r_h_sq[1]) + SUM_W'(r_h_sq[2]);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:0], i_valid};
        end
    end

    assign o_valid = r_vld[8];
    assign o_carry = r_i_car;
    assign o_sum   = r_i_sum;

endmodule

/* rtl/tpq_sqrt.sv */
module tpq_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  tpq_pkg::t_carry                 i_carry,
    input  logic [tpq_pkg::SUM_W-1:0]       i_sum,
    output logic                            o_valid,
    output tpq_pkg::t_carry                 o_carry,
    output logic [tpq_pkg::ROOT_BITS-1:0]   o_root
);
    import tpq_pkg::*;

    // One result bit per stage, restoring digit-by-digit square root.
    logic [ROOT_BITS-1:0] r_vld;
    logic [SUM_W-1:0]     r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS];
    t_carry               r_car  [ROOT_BITS];

    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
        localparam int K = ROOT_BITS - 1 - j;

        logic [SUM_W-1:0]     w_rem_in;
        logic [SUM_W-1:0]     w_trial;
        logic [ROOT_BITS-1:0] w_root_in;
        t_carry               w_car_in;
        logic                 w_vld_in;

        if (j == 0) begin : g_first
            assign w_rem_in  = i_sum;
            assign w_root_in = '0;
            assign w_car_in  = i_carry;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
            assign w_car_in  = r_car[j-1];
            assign w_vld_in  = r_vld[j-1];
        end

        // Trial value for setting bit K: (root + 2^K)^2 - root^2.
        assign w_trial = (SUM_W'(w_root_in) << (K + 1)) | (SUM_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_car[j] <= w_car_in;
                if (w_rem_in >= w_trial) begin
                    r_rem[j]  <= w_rem_in - w_trial;
                    r_root[j] <= w_root_in | (ROOT_BITS'(1) << K);
                end else begin
                    r_rem[j]  <= w_rem_in;
                    r_root[j] <= w_root_in;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_BITS-1];
    assign o_carry = r_car[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];

endmodule

/* rtl/tpq_div.sv */
module tpq_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tpq_pkg::t_carry                     i_carry,
    input  logic [tpq_pkg::ROOT_BITS-1:0]       i_root,
    output logic                                o_valid,
    output tpq_pkg::t_carry                     o_carry,
    output logic [2:0][tpq_pkg::QUO_BITS-1:0]   o_quo
);
    import tpq_pkg::*;

    // Set-up stage: rounded numerators and a nonzero divisor.
    logic                 r_s_vld;
    t_carry               r_s_car;
    logic [ROOT_BITS-1:0] r_s_len;
    logic [NUM_W-1:0]     r_s_num [3];
    logic [ROOT_BITS-1:0] w_len;

    assign w_len = (i_root == '0) ? ROOT_BITS'(1) : i_root;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_car <= i_carry;
            r_s_len <= w_len;
            for (int i = 0; i < 3; i++) begin
                r_s_num[i] <= (NUM_W'(i_carry.m[i]) << U_FRAC) + NUM_W'(w_len >> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (i_en) begin
            r_s_vld <= i_valid;
        end
    end

    // Restoring division, one quotient bit per stage in each of three lanes.
    logic [QUO_BITS-1:0]  r_vld;
    t_carry               r_car [QUO_BITS];
    logic [ROOT_BITS-1:0] r_len [QUO_BITS];
    logic [NUM_W-1:0]     r_rem [QUO_BITS][3];
    logic [QUO_BITS-1:0]  r_quo [QUO_BITS][3];

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
        localparam int K = QUO_BITS - 1 - j;

        logic                 w_vld_in;
        t_carry               w_car_in;
        logic [ROOT_BITS-1:0] w_len_in;
        logic [NUM_W-1:0]     w_rem_in [3];
        logic [QUO_BITS-1:0]  w_quo_in [3];
        logic [NUM_W-1:0]     w_dvs;

        if (j == 0) begin : g_first
            assign w_vld_in = r_s_vld;
            assign w_car_in = r_s_car;
            assign w_len_in = r_s_len;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem_in[l] = r_s_num[l];
                assign w_quo_in[l] = '0;
            end
        end else begin : g_next
            assign w_vld_in = r_vld[j-1];
            assign w_car_in = r_car[j-1];
            assign w_len_in = r_len[j-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem_in[l] = r_rem[j-1][l];
                assign w_quo_in[l] = r_quo[j-1][l];
            end
        end

        assign w_dvs = NUM_W'(w_len_in) << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_car[j] <= w_car_in;
                r_len[j] <= w_len_in;
                for (int l = 0; l < 3; l++) begin
                    if (w_rem_in[l] >= w_dvs) begin
                        r_rem[j][l] <= w_rem_in[l] - w_dvs;
                        r_quo[j][l] <= w_quo_in[l] | (QUO_BITS'(1) << K);
                    end else begin
                        r_rem[j][l] <= w_rem_in[l];
                        r_quo[j][l] <= w_quo_in[l];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld_in;
            end
        end
    end

    assign o_valid = r_vld[QUO_BITS-1];
    assign o_carry = r_car[QUO_BITS-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_quo[QUO_BITS-1][l];
        end
    end

endmodule

/* rtl/tpq_back.sv */
module tpq_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tpq_pkg::t_carry                     i_carry,
    input  logic [2:0][tpq_pkg::QUO_BITS-1:0]   i_quo,
    output logic                                o_valid,
    output tpq_pkg::t_result                    o_result
);
    import tpq_pkg::*;

    localparam logic [QUO_BITS-1:0] U_ONE = QUO_BITS'(1) << U_FRAC;

    // Round a magnitude by 2^k with halves away from zero, saturate, apply the sign.
    function automatic logic [63:0] round_sat(input logic [127:0] mag, input int k,
                                              input logic neg);
        logic [128:0] sum;
        logic [128:0] rnd;
        logic [63:0]  lim;
        logic [63:0]  val;
        sum = {1'b0, mag} + (129'(1) << (k - 1));
        rnd = sum >> k;
        lim = neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        if (rnd > 129'(lim)) begin
            val = lim;
        end else begin
            val = rnd[63:0];
        end
        return neg ? (64'(0) - val) : val;
    endfunction

    logic [6:0] r_vld;

    // P1: signed unit normal.
    logic [2:0][31:0]   r_1_a;
    logic               r_1_degen;
    logic signed [31:0] r_1_u [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_1_a     <= i_carry.a;
            r_1_degen <= i_carry.degen;
            for (int i = 0; i < 3; i++) begin
                if (i_carry.neg[i]) begin
                    r_1_u[i] <= -32'((i_quo[i] > U_ONE) ? U_ONE : i_quo[i]);
                end else begin
                    r_1_u[i] <= 32'((i_quo[i] > U_ONE) ? U_ONE : i_quo[i]);
                end
            end
        end
    end

    // P2: products for the dot product and the normal-by-normal entries.
    logic               r_2_degen;
    logic signed [31:0] r_2_u  [3];
    logic signed [63:0] r_2_ua [3];
    logic signed [63:0] r_2_uu [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_2_degen <= r_1_degen;
            r_2_u     <= r_1_u;
            for (int i = 0; i < 3; i++) begin
                r_2_ua[i] <= r_1_u[i] * signed'(r_1_a[i]);
            end
            r_2_uu[0] <= r_1_u[0] * r_1_u[0];
            r_2_uu[1] <= r_1_u[0] * r_1_u[1];
            r_2_uu[2] <= r_1_u[0] * r_1_u[2];
            r_2_uu[3] <= r_1_u[1] * r_1_u[1];
            r_2_uu[4] <= r_1_u[1] * r_1_u[2];
            r_2_uu[5] <= r_1_u[2] * r_1_u[2];
        end
    end

    // P3: dot product and rounding of the normal-by-normal entries.
    logic               r_3_degen;
    logic signed [31:0] r_3_u  [3];
    logic signed [63:0] r_3_dot;
    logic [63:0]        r_3_uu [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_3_degen <= r_2_degen;
            r_3_u     <= r_2_u;
            r_3_dot   <= r_2_ua[0] + r_2_ua[1] + r_2_ua[2];
            for (int i = 0; i < 6; i++) begin
                r_3_uu[i] <= round_sat(128'(r_2_uu[i][63] ? -r_2_uu[i] : r_2_uu[i]),
                                       K_UU, r_2_uu[i][63]);
            end
        end
    end

    // P4: magnitudes and signs of the offset entries.
    logic                r_4_degen;
    logic [63:0]         r_4_uu [6];
    logic [63:0]         r_4_dmag;
    logic [QUO_BITS-1:0] r_4_umag [3];
    logic [2:0]          r_4_ng;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_4_degen <= r_3_degen;
            r_4_uu    <= r_3_uu;
            r_4_dmag  <= r_3_dot[63] ? 64'(-r_3_dot) : 64'(r_3_dot);
            for (int i = 0; i < 3; i++) begin
                r_4_umag[i] <= QUO_BITS'(r_3_u[i][31] ? -r_3_u[i] : r_3_u[i]);
                r_4_ng[i]   <= (r_3_u[i] != 0) && (r_3_dot != 0)
                               && (r_3_u[i][31] == r_3_dot[63]);
            end
        end
    end

    // P5: 32-bit partial products of the wide offset terms.
    logic                         r_5_degen;
    logic [63:0]                  r_5_uu  [6];
    logic [2:0]                   r_5_ng;
    logic [QUO_BITS+31:0]         r_5_udl [3];
    logic [QUO_BITS+31:0]         r_5_udh [3];
    logic [63:0]                  r_5_dhh;
    logic [63:0]                  r_5_dhl;
    logic [63:0]                  r_5_dll;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_5_degen <= r_4_degen;
            r_5_uu    <= r_4_uu;
            r_5_ng    <= r_4_ng;
            for (int i = 0; i < 3; i++) begin
                r_5_udl[i] <= r_4_umag[i] * r_4_dmag[31:0];
                r_5_udh[i] <= r_4_umag[i] * r_4_dmag[63:32];
            end
            r_5_dhh <= r_4_dmag[63:32] * r_4_dmag[63:32];
            r_5_dhl <= r_4_dmag[63:32] * r_4_dmag[31:0];
            r_5_dll <= r_4_dmag[31:0] * r_4_dmag[31:0];
        end
    end

    // P6: assemble the full-width products.
    logic         r_6_degen;
    logic [63:0]  r_6_uu [6];
    logic [2:0]   r_6_ng;
    logic [127:0] r_6_ud [3];
    logic [127:0] r_6_dd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_6_degen <= r_5_degen;
            r_6_uu    <= r_5_uu;
            r_6_ng    <= r_5_ng;
            for (int i = 0; i < 3; i++) begin
                r_6_ud[i] <= (128'(r_5_udh[i]) << 32) + 128'(r_5_udl[i]);
            end
            r_6_dd <= (128'(r_5_dhh) << 64) + (128'(r_5_dhl) << 33) + 128'(r_5_dll);
        end
    end

    // P7: round and saturate the offset entries, zero a degenerate triangle.
    t_result r_7_res;
    t_result w_res;

    always_comb begin
        w_res.degen   = r_6_degen;
        w_res.q[Q_XX] = r_6_uu[0];
        w_res.q[Q_XY] = r_6_uu[1];
        w_res.q[Q_XZ] = r_6_uu[2];
        w_res.q[Q_YY] = r_6_uu[3];
        w_res.q[Q_YZ] = r_6_uu[4];
        w_res.q[Q_ZZ] = r_6_uu[5];
        w_res.q[Q_XD] = round_sat(r_6_ud[0], K_UD, r_6_ng[0]);
        w_res.q[Q_YD] = round_sat(r_6_ud[1], K_UD, r_6_ng[1]);
        w_res.q[Q_ZD] = round_sat(r_6_ud[2], K_UD, r_6_ng[2]);
        w_res.q[Q_DD] = round_sat(r_6_dd, K_DD, 1'b0);
        if (r_6_degen) begin
            w_res.q = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_7_res <= w_res;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    assign o_valid  = r_vld[6];
    assign o_result = r_7_res;

endmodule

/* test/tb_triangle_plane_quadric.sv */
module tb_triangle_plane_quadric;
    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    localparam int NUM_RANDOM = 1730;
    localparam int LATENCY    = 79;
    localparam int CYCLE_CAP  = 400000;

    // Three vertices in the order a_x, a_y, a_z, b_x, ..., c_z.
    typedef logic [8:0][31:0] t_tri;

    typedef struct {
        longint q[NUM_Q];
        bit     degen;
    } t_quadric;

    typedef enum int {ROW_PREDICT, ROW_DEGEN, ROW_UNIT_Z} t_row_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic signed [31:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic        o_valid;
    logic        i_ready;
    logic signed [63:0] o_q_xx, o_q_xy, o_q_xz, o_q_xd, o_q_yy;
    logic signed [63:0] o_q_yz, o_q_yd, o_q_zz, o_q_zd, o_q_dd;
    logic        o_degenerate;

    t_quadric pending_quadrics[$];
    int       error_count;
    int       cycle_count;
    bit       no_stall_mode;

    triangle_plane_quadric u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_q_xx(o_q_xx), .o_q_xy(o_q_xy), .o_q_xz(o_q_xz), .o_q_xd(o_q_xd),
        .o_q_yy(o_q_yy), .o_q_yz(o_q_yz), .o_q_yd(o_q_yd), .o_q_zz(o_q_zz),
        .o_q_zd(o_q_zd), .o_q_dd(o_q_dd), .o_degenerate(o_degenerate)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic t_tri mk(input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        t_tri t;
        t[0] = ax; t[1] = ay; t[2] = az;
        t[3] = bx; t[4] = by; t[5] = bz;
        t[6] = cx; t[7] = cy; t[8] = cz;
        return t;
    endfunction

    // Round a magnitude by 2^k, halves away from zero, saturate and apply the sign.
    function automatic longint round_sat(input logic [127:0] mag, input int k, input bit ng);
        logic [128:0] r;
        logic [128:0] limit;
        logic [63:0]  v;
        r = ({1'b0, mag} + (129'd1 << (k - 1))) >> k;
        limit = ng ? (129'd1 << 63) : ((129'd1 << 63) - 129'd1);
        if (r > limit) r = limit;
        v = r[63:0];
        return ng ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic [127:0] mag128(input longint x);
        return x < 0 ? 128'(-x) : 128'(x);
    endfunction

    // Plane quadric of one triangle in fixed point.
    function automatic t_quadric plane_quadric(input t_tri v);
        t_quadric res;
        longint a[3];
        logic signed [67:0] e1[3], e2[3], nv[3];
        logic [66:0] nm[3], all_bits;
        logic [63:0] mm[3], s, len, t, quo;
        longint u[3], dotp;
        int bl;
        int idx[3][3];
        int dix[3];
        bit ng;
        idx[0][0] = Q_XX; idx[0][1] = Q_XY; idx[0][2] = Q_XZ;
        idx[1][1] = Q_YY; idx[1][2] = Q_YZ; idx[2][2] = Q_ZZ;
        dix[0] = Q_XD; dix[1] = Q_YD; dix[2] = Q_ZD;
        for (int i = 0; i < NUM_Q; i++) res.q[i] = 0;
        res.degen = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(signed'(v[i]));
            e1[i] = longint'(signed'(v[3 + i])) - a[i];
            e2[i] = longint'(signed'(v[6 + i])) - a[i];
        end
        nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
        all_bits = '0;
        for (int i = 0; i < 3; i++) begin
            nm[i] = nv[i] < 0 ? 67'(-nv[i]) : 67'(nv[i]);
            all_bits |= nm[i];
        end
        bl = 0;
        for (int b = 0; b < 67; b++) if (all_bits[b]) bl = b + 1;
        if (bl == 0) begin
            res.degen = 1'b1;
            return res;
        end

        // Bring the largest component into [2^29, 2^30).
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (bl > NORM_BITS) mm[i] = 64'(nm[i] >> (bl - NORM_BITS));
            else mm[i] = 64'(nm[i] << (NORM_BITS - bl));
            s += mm[i] * mm[i];
        end
        len = 0;
        for (int b = 31; b >= 0; b--) begin
            t = len | (64'd1 << b);
            if (t * t <= s) len = t;
        end
        if (len == 0) len = 1;

        // Unit normal and the exact dot product with the first vertex.
        dotp = 0;
        for (int i = 0; i < 3; i++) begin
            quo = ((mm[i] << U_FRAC) + (len >> 1)) / len;
            if (quo > (64'd1 << U_FRAC)) quo = 64'd1 << U_FRAC;
            u[i] = nv[i] < 0 ? -longint'(quo) : longint'(quo);
            dotp += u[i] * a[i];
        end

        for (int i = 0; i < 3; i++) begin
            for (int j = i; j < 3; j++) begin
                ng = ((u[i] < 0) != (u[j] < 0)) && u[i] != 0 && u[j] != 0;
                res.q[idx[i][j]] = round_sat(mag128(u[i]) * mag128(u[j]), K_UU, ng);
            end
            ng = u[i] != 0 && dotp != 0 && ((u[i] < 0) == (dotp < 0));
            res.q[dix[i]] = round_sat(mag128(u[i]) * mag128(dotp), K_UD, ng);
        end
        res.q[Q_DD] = round_sat(mag128(dotp) * mag128(dotp), K_DD, 1'b0);
        return res;
    endfunction

    // Result side: random stalls, and every result checked against the oldest prediction.
    always @(posedge i_clk) begin
        static int stall = 0;
        t_quadric want;
        longint got[NUM_Q];
        string names[NUM_Q];
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_q_xx, o_q_xy, o_q_xz, o_q_xd, o_q_yy,
                        o_q_yz, o_q_yd, o_q_zz, o_q_zd, o_q_dd};
                names = '{"q_xx", "q_xy", "q_xz", "q_xd", "q_yy",
                          "q_yz", "q_yd", "q_zz", "q_zd", "q_dd"};
                if (pending_quadrics.size() == 0) begin
                    report("result item with no prediction waiting", 0, 0);
                end else begin
                    want = pending_quadrics.pop_front();
                    for (int i = 0; i < NUM_Q; i++)
                        if (got[i] != want.q[i]) report(names[i], got[i], want.q[i]);
                    if (o_degenerate !== want.degen)
                        report("degenerate", longint'(o_degenerate), longint'(want.degen));
                end
                stall = no_stall_mode ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one triangle after a random gap and wait for it to be taken.
    task automatic send_triangle(input t_tri v, input t_quadric want);
        int gap;
        gap = no_stall_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_a_x <= v[0]; i_a_y <= v[1]; i_a_z <= v[2];
        i_b_x <= v[3]; i_b_y <= v[4]; i_b_z <= v[5];
        i_c_x <= v[6]; i_c_y <= v[7]; i_c_z <= v[8];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_quadrics = {pending_quadrics, want};
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // Random triangle: fully random or ordinary meshes, with extremes and flat ones mixed in.
    function automatic t_tri random_triangle();
        t_tri t;
        logic [31:0] base, span;
        int sel;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) t[i] = $urandom;
        case (sel)
            4, 5, 6, 7: begin
                span = 32'd1 << $urandom_range(0, 24);
                for (int i = 0; i < 3; i++) begin
                    base = $urandom;
                    t[i]     = base;
                    t[3 + i] = base + $urandom_range(0, span) - span / 2;
                    t[6 + i] = base + $urandom_range(0, span) - span / 2;
                end
            end
            8: for (int i = 0; i < 9; i++) t[i] = pick_extreme();
            9: begin
                // Flat triangle: repeated vertex or c on the line through a and b.
                for (int i = 0; i < 3; i++) begin
                    t[i] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                    t[3 + i] = t[i] + $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
                    t[6 + i] = $urandom_range(0, 1) ? t[i] : 32'(2 * t[3 + i] - t[i]);
                end
            end
            default: ;
        endcase
        return t;
    endfunction

    initial begin
        t_tri      rows[13];
        t_row_kind kinds[13];
        t_quadric  want;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
        error_count = 0;
        cycle_count = 0;
        no_stall_mode = 1'b0;

        rows[0]  = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        kinds[0] = ROW_DEGEN;
        rows[1]  = mk('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                      '1 >> 1, '1 >> 1, '1 >> 1);
        kinds[1] = ROW_DEGEN;
        rows[2]  = mk({8{4'h8}} & 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        kinds[2] = ROW_DEGEN;
        rows[3]  = mk(0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                      32'h2_0000, 32'h2_0000, 32'h2_0000);
        kinds[3] = ROW_DEGEN;
        // Unit triangle in the xy plane through the origin: only q_zz is one.
        rows[4]  = mk(0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0);
        kinds[4] = ROW_UNIT_Z;
        rows[5]  = mk(0, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 0, 0);
        rows[6]  = mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        rows[7]  = mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
        rows[8]  = mk(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
                      32'h7FFF_0001, 32'h7FFF_0000, 32'h7FFF_0000,
                      32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0001);
        rows[9]  = mk(0, 0, 0, 1, 0, 0, 0, 1, 0);
        rows[10] = mk('1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        rows[11] = mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        rows[12] = mk(32'h0012_3456, 32'hFFED_CBA9, 32'h0001_0000, 32'h0023_0000,
                      32'hFFF0_0000, 32'h0005_8000, 32'hFFFF_0000, 32'h0009_0000, 0);
        for (int r = 5; r < 13; r++) kinds[r] = ROW_PREDICT;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed triangles.
        foreach (rows[r]) begin
            want = plane_quadric(rows[r]);
            if (kinds[r] != ROW_PREDICT) begin
                for (int i = 0; i < NUM_Q; i++) want.q[i] = 0;
                want.degen = kinds[r] == ROW_DEGEN;
                if (kinds[r] == ROW_UNIT_Z) want.q[Q_ZZ] = 64'd1 << 32;
            end
            send_triangle(rows[r], want);
        end

        // Random triangles, with bursts of no idling and one full drain midway.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            t_tri t;
            if (n % 50 == 0) no_stall_mode = $urandom_range(0, 3) == 0;
            if (n == NUM_RANDOM / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_quadrics.size() != 0) @(posedge i_clk);
            end
            t = random_triangle();
            send_triangle(t, plane_quadric(t));
        end
        i_valid <= 1'b0;

        while (pending_quadrics.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
